// ===== rtl/itoa_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// itoa_pkg
// Shared types and constants for the integer to ASCII radix converter.
// ----------------------------------------------------------------------------
package itoa_pkg;

    localparam int unsigned PointerWidthDefault = 64;
    localparam int unsigned MaxChars            = 18;
    localparam int unsigned DecDigits           = 10;
    localparam int unsigned BcdWidth            = 4 * DecDigits;

    typedef enum logic [2:0] {
        CMD_SDEC = 3'd0,
        CMD_OCT  = 3'd1,
        CMD_UDEC = 3'd2,
        CMD_HEX  = 3'd3,
        CMD_PTR  = 3'd4
    } t_cmd;

    localparam logic [7:0] ChZero  = 8'h30;
    localparam logic [7:0] ChLowA  = 8'h61;
    localparam logic [7:0] ChMinus = 8'h2d;
    localparam logic [7:0] ChX     = 8'h78;

    // one double-dabble adjust: add three to every digit at five or more; the caller does the shift
    function automatic logic [BcdWidth-1:0] dabble_adjust(input logic [BcdWidth-1:0] b);
        logic [BcdWidth-1:0] r;
        r = b;
        for (int d = 0; d < DecDigits; d++) begin
            if (r[4*d +: 4] >= 4'd5) begin
                r[4*d +: 4] = r[4*d +: 4] + 4'd3;
            end
        end
        return r;
    endfunction

    function automatic logic [7:0] nibble_char(input logic [3:0] n);
        logic [7:0] c;
        if (n > 4'd9) begin
            c = ChLowA + {4'd0, n} - 8'd10;
        end else begin
            c = ChZero + {4'd0, n};
        end
        return c;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/itoa_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// itoa_if
// Valid/ready stream channel with a generic payload.
// ----------------------------------------------------------------------------
interface itoa_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== rtl/integer_to_ascii_radix.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// integer_to_ascii_radix
// Number to ASCII text: 32-bit signed/unsigned decimal, octal, hex, pointer.
// ----------------------------------------------------------------------------
// Pipeline: decode, 8 double-dabble stages of 4 bits each, then format into
//   the serializer.
// Throughput: one character per cycle while o_out.ready holds; an item's text
//   has 1 to 18 characters, and the serializer at the output sets the pace.
// The conversion pipe accepts a new item every cycle while it moves.
// Reset: synchronous, active low, clears every valid bit and the serializer's busy flag and index.
// ----------------------------------------------------------------------------
module integer_to_ascii_radix #(
    parameter int unsigned POINTER_WIDTH = itoa_pkg::PointerWidthDefault
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    itoa_if.sink      i_in,
    itoa_if.source    o_out
);

    localparam int unsigned Stages   = 8;
    localparam int unsigned BitsStep = 32 / Stages;
    localparam int unsigned BW       = itoa_pkg::BcdWidth;

    typedef struct packed {
        logic              neg;
        logic              dec;
        logic              oct;
        logic              ptr;
        logic [31:0]       bin;
        logic [BW-1:0]     bcd;
        logic [63:0]       raw;
    } t_work;

    logic           adv;
    logic           r_vld [Stages+1];
    t_work          r_w   [Stages+1];
    logic           pipe_ready;

    // ---------------- stage 0: decode and magnitude
    t_work          n_w0;
    logic           n_v0;
    logic [31:0]    low;
    logic [63:0]    pmask;

    always_comb begin
        low   = i_in.payload.value[31:0];
        pmask = (POINTER_WIDTH >= 64) ? '1 : ((64'd1 << POINTER_WIDTH) - 64'd1);
        n_w0  = '0;
        n_v0  = i_in.valid;
        case (i_in.payload.cmd)
            itoa_pkg::CMD_SDEC: begin
                n_w0.dec = 1'b1;
                n_w0.neg = low[31];
                n_w0.bin = low[31] ? (32'd0 - low) : low;
            end
            itoa_pkg::CMD_OCT: begin
                n_w0.oct = 1'b1;
                n_w0.raw = {32'd0, low};
            end
            itoa_pkg::CMD_UDEC: begin
                n_w0.dec = 1'b1;
                n_w0.bin = low;
            end
            itoa_pkg::CMD_HEX: n_w0.raw = {32'd0, low};
            itoa_pkg::CMD_PTR: begin
                n_w0.ptr = 1'b1;
                n_w0.raw = i_in.payload.value & pmask;
            end
            default: n_v0 = 1'b0;
        endcase
    end

    assign i_in.ready = pipe_ready;
    assign adv        = pipe_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (adv) begin
            r_vld[0] <= n_v0;
        end
        if (adv) begin
            r_w[0] <= n_w0;
        end
    end

    // ---------------- stages 1..8: double-dabble, four bits per stage
    for (genvar s = 0; s < Stages; s++) begin : g_dd
        t_work n_w;
        always_comb begin
            n_w = r_w[s];
            for (int b = 0; b < BitsStep; b++) begin
                n_w.bcd = itoa_pkg::dabble_adjust(n_w.bcd);
                n_w.bcd = {n_w.bcd[BW-2:0], n_w.bin[31]};
                n_w.bin = {n_w.bin[30:0], 1'b0};
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s+1] <= 1'b0;
            end else if (adv) begin
                r_vld[s+1] <= r_vld[s];
            end
            if (adv) begin
                r_w[s+1] <= n_w;
            end
        end
    end

    // ---------------- format: build the character buffer and length
    localparam int unsigned MC = itoa_pkg::MaxChars;
    localparam int unsigned LW = $clog2(MC + 1);

    logic [MC-1:0][7:0] n_buf;
    logic [LW-1:0]      n_len;
    t_work              f;
    logic [4:0]         nd;
    logic [3:0]         dg [22];
    logic [4:0]         base;

    always_comb begin
        f     = r_w[Stages];
        n_buf = '0;
        nd    = 5'd1;
        for (int i = 0; i < 22; i++) dg[i] = 4'd0;
        if (f.dec) begin
            for (int i = 0; i < 10; i++) dg[i] = f.bcd[4*i +: 4];
            for (int i = 1; i < 10; i++) if (dg[i] != 4'd0) nd = 5'(i + 1);
        end else if (f.oct) begin
            for (int i = 0; i < 11; i++) dg[i] = {1'b0, f.raw[3*i +: 3]} & 4'h7;
            dg[10] = {2'b00, f.raw[31:30]};
            for (int i = 1; i < 11; i++) if (dg[i] != 4'd0) nd = 5'(i + 1);
        end else begin
            for (int i = 0; i < 16; i++) dg[i] = f.raw[4*i +: 4];
            for (int i = 1; i < 16; i++) if (dg[i] != 4'd0) nd = 5'(i + 1);
        end
        base = 5'd0;
        if (f.ptr) begin
            n_buf[0] = itoa_pkg::ChZero;
            n_buf[1] = itoa_pkg::ChX;
            base     = 5'd2;
        end
        if (f.neg) begin
            n_buf[0] = itoa_pkg::ChMinus;
            base     = 5'd1;
        end
        for (int k = 0; k < 16; k++) begin
            if (5'(k) < nd) begin
                n_buf[5'(k) + base] = itoa_pkg::nibble_char(dg[nd - 5'd1 - 5'(k)]);
            end
        end
        n_len = LW'(base + nd);
    end

    // ---------------- serializer
    logic [MC-1:0][7:0] r_buf;
    logic [LW-1:0]      r_len;
    logic [LW-1:0]      r_idx;
    logic               r_busy;
    logic               take;
    logic               fin;

    assign fin        = o_out.ready && (r_idx == r_len - LW'(1));
    assign take       = r_vld[Stages] && (!r_busy || fin);
    assign pipe_ready = !r_vld[Stages] || take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (take) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (r_busy && o_out.ready) begin
            if (fin) begin
                r_busy <= 1'b0;
            end
            r_idx <= r_idx + LW'(1);
        end
        if (take) begin
            r_buf <= n_buf;
            r_len <= n_len;
        end
    end

    assign o_out.valid            = r_busy;
    assign o_out.payload.char_out = r_buf[r_idx[$clog2(MC)-1:0]];
    assign o_out.payload.last     = (r_idx == r_len - LW'(1));

endmodule
`default_nettype wire
